// ===== design/chd_pkg.sv =====
package chd_pkg;

    // Field widths of the channels.
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    // Default for the longest accepted size field, in hex digits.
    localparam int MAX_SIZE_DIGITS_DEF = 8;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // End-of-body status codes.
    localparam logic [STATUS_W-1:0] ST_TERMINATED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SIZE_TOO_LONG = 2'd2;

    // Line control characters.
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    // One result item.
    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [STATUS_W-1:0] end_status;
        logic [COUNT_W-1:0]  payload_count;
    } result_t;

    // Up to two results produced by one input transaction, in order.
    typedef struct packed {
        logic    first_valid;
        result_t first;
        logic    second_valid;
        result_t second;
    } push_t;

    // True for an ASCII hex digit of either case.
    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Value of a hex digit; only meaningful when is_hex is true.
    function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = 8'h00;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61)
        begin
            v = c - 8'h57;
        end
        else
        begin
            v = c - 8'h37;
        end
        hex_digit = v[3:0];
    endfunction

endpackage

// ===== design/chd_in_if.sv =====
interface chd_in_if
    import chd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] input_byte;
    logic              last_byte;

    modport source (output valid, output input_byte, output last_byte, input ready);
    modport sink   (input valid, input input_byte, input last_byte, output ready);
endinterface

// ===== design/chd_out_if.sv =====
interface chd_out_if
    import chd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] end_status;
    logic [COUNT_W-1:0]  payload_count;

    modport source (output valid, output item_kind, output payload_byte,
                    output end_status, output payload_count, input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input end_status, input payload_count, output ready);
endinterface

// ===== design/chd_parser.sv =====
module chd_parser
    import chd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = MAX_SIZE_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              room,
    output push_t             push
);

    localparam int CNT_W = $clog2(MAX_SIZE_DIGITS + 1);

    typedef enum logic [6:0] {
        PH_SIZE       = 7'b0000001,
        PH_EXT        = 7'b0000010,
        PH_DATA       = 7'b0000100,
        PH_AFTER_DATA = 7'b0001000,
        PH_AFTER_CR   = 7'b0010000,
        PH_DONE       = 7'b0100000,
        PH_ERROR      = 7'b1000000
    } phase_t;

    // Input register stage.
    logic              hold_valid_reg;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              hold_last_reg;
    logic              fire;

    // Decoder state.
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   digits_reg, digits_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;

    // Outcome of treating the held byte as a size-line byte.
    phase_t             sz_phase;
    logic [COUNT_W-1:0] sz_acc;
    logic [CNT_W-1:0]   sz_digits;
    logic [COUNT_W-1:0] sz_remain;

    // Outcome of closing the size line with the current accumulator.
    phase_t             eol_phase;
    logic [COUNT_W-1:0] eol_remain;

    logic [STATUS_W-1:0] status;
    logic                emit_data;
    result_t             data_item;
    result_t             sum_item;

    assign fire     = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= in_last;
        end
    end

    // End of a size line: zero ends the body, otherwise data follows.
    always_comb
    begin
        if (acc_reg == '0)
        begin
            eol_phase  = PH_DONE;
            eol_remain = remain_reg;
        end
        else
        begin
            eol_phase  = PH_DATA;
            eol_remain = acc_reg;
        end
    end

    // Size-line byte: digit accumulate or too-long error, LF close, other opens extension.
    always_comb
    begin
        sz_phase  = PH_SIZE;
        sz_acc    = acc_reg;
        sz_digits = digits_reg;
        sz_remain = remain_reg;
        if (is_hex(hold_byte_reg))
        begin
            if (digits_reg == CNT_W'(MAX_SIZE_DIGITS))
            begin
                sz_phase = PH_ERROR;
            end
            else
            begin
                sz_digits = digits_reg + CNT_W'(1);
                if (|acc_reg[COUNT_W-1:COUNT_W-4])
                begin
                    sz_acc = '1;
                end
                else
                begin
                    sz_acc = {acc_reg[COUNT_W-5:0], hex_digit(hold_byte_reg)};
                end
            end
        end
        else if (hold_byte_reg == CH_LF)
        begin
            sz_phase  = eol_phase;
            sz_remain = eol_remain;
            sz_acc    = '0;
            sz_digits = '0;
        end
        else
        begin
            sz_phase = PH_EXT;
        end
    end

    // Per-byte phase update.
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        digits_next  = digits_reg;
        remain_next  = remain_reg;
        emitted_next = emitted_reg;
        emit_data    = 1'b0;
        case (phase_reg)
            PH_SIZE:
            begin
                phase_next  = sz_phase;
                acc_next    = sz_acc;
                digits_next = sz_digits;
                remain_next = sz_remain;
            end
            PH_EXT:
            begin
                if (hold_byte_reg == CH_LF)
                begin
                    phase_next  = eol_phase;
                    remain_next = eol_remain;
                    acc_next    = '0;
                    digits_next = '0;
                end
            end
            PH_DATA:
            begin
                emit_data   = 1'b1;
                remain_next = remain_reg - COUNT_W'(1);
                if (!(&emitted_reg))
                begin
                    emitted_next = emitted_reg + COUNT_W'(1);
                end
                if (remain_reg == COUNT_W'(1))
                begin
                    phase_next = PH_AFTER_DATA;
                end
            end
            PH_AFTER_DATA:
            begin
                if (hold_byte_reg == CH_CR)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else if (hold_byte_reg == CH_LF)
                begin
                    phase_next = PH_SIZE;
                end
                else
                begin
                    phase_next  = sz_phase;
                    acc_next    = sz_acc;
                    digits_next = sz_digits;
                    remain_next = sz_remain;
                end
            end
            PH_AFTER_CR:
            begin
                phase_next = PH_SIZE;
                if (hold_byte_reg != CH_LF)
                begin
                    phase_next  = sz_phase;
                    acc_next    = sz_acc;
                    digits_next = sz_digits;
                    remain_next = sz_remain;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Summary status from the phase after this byte.
    always_comb
    begin
        case (phase_next)
            PH_DONE:  status = ST_TERMINATED;
            PH_ERROR: status = ST_SIZE_TOO_LONG;
            default:  status = ST_TRUNCATED;
        endcase
    end

    // Result items for this transaction.
    always_comb
    begin
        data_item.item_kind     = KIND_PAYLOAD;
        data_item.payload_byte  = hold_byte_reg;
        data_item.end_status    = ST_TERMINATED;
        data_item.payload_count = '0;

        sum_item.item_kind      = KIND_SUMMARY;
        sum_item.payload_byte   = '0;
        sum_item.end_status     = status;
        sum_item.payload_count  = emitted_next;

        push.first_valid  = fire && (emit_data || hold_last_reg);
        push.first        = emit_data ? data_item : sum_item;
        push.second_valid = fire && emit_data && hold_last_reg;
        push.second       = sum_item;
    end

    // State registers; the last byte returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIZE;
            acc_reg     <= '0;
            digits_reg  <= '0;
            remain_reg  <= '0;
            emitted_reg <= '0;
        end
        else if (fire)
        begin
            if (hold_last_reg)
            begin
                phase_reg   <= PH_SIZE;
                acc_reg     <= '0;
                digits_reg  <= '0;
                remain_reg  <= '0;
                emitted_reg <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                digits_reg  <= digits_next;
                remain_reg  <= remain_next;
                emitted_reg <= emitted_next;
            end
        end
    end

endmodule

// ===== design/chd_out_queue.sv =====
module chd_out_queue
    import chd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [CNT_W-1:0] n_push;

    // Room is reserved for the largest burst of one transaction.
    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        n_push      = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, written in transaction order.
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            slot_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== design/http_chunked_decoder_top.sv =====
// Channel  Role    Payload
// rx       sink    input_byte[7:0], last_byte
// tx       source  item_kind, payload_byte[7:0], end_status[1:0], payload_count[31:0]
//
// One byte is accepted per cycle while the queue has room; its results are then queued.
// A payload byte that is also the last byte yields two results, as two tx transfers.
// A four-entry result queue decouples tx stalls; rx stalls only when it is nearly full.
// Reset (rst_n low) clears the decoder to the start of a size line and empties the queue.
module http_chunked_decoder_top
    import chd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = MAX_SIZE_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    chd_in_if.sink      rx,
    chd_out_if.source   tx
);

    push_t   push;
    logic    room;
    result_t out_item;

    // Byte decoder with its input register.
    chd_parser #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .in_byte  (rx.input_byte),
        .in_last  (rx.last_byte),
        .room     (room),
        .push     (push)
    );

    // Result queue feeding the output channel.
    chd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .out_item  (out_item)
    );

    assign tx.item_kind     = out_item.item_kind;
    assign tx.payload_byte  = out_item.payload_byte;
    assign tx.end_status    = out_item.end_status;
    assign tx.payload_count = out_item.payload_count;

endmodule

// ===== sim/tb_http_chunked_decoder_top.sv =====
`timescale 1ns / 100ps

module tb_http_chunked_decoder_top;
    import chd_pkg::*;

    localparam int SIZE_DIGITS = MAX_SIZE_DIGITS_DEF;
    localparam int DRILL_ROWS  = 26;
    localparam int BUSY_TARGET = 1600;
    localparam int CALM_FROM   = 1350;

    // Decoder phases of the predictor.
    typedef enum logic [2:0] {
        DEC_SIZE,
        DEC_EXT,
        DEC_DATA,
        DEC_AFTER_DATA,
        DEC_AFTER_CR,
        DEC_DONE,
        DEC_ERROR
    } dec_phase_e;

    // One row of the directed stimulus; a summary is typed in where checked is set.
    typedef struct {
        logic [BYTE_W-1:0]   data;
        logic                is_last;
        bit                  checked;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } drill_row_t;

    logic clk;
    logic rst_n;

    chd_in_if  rx_if ();
    chd_out_if tx_if ();

    http_chunked_decoder_top #(
        .MAX_SIZE_DIGITS (SIZE_DIGITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    // Predictor state.
    dec_phase_e         dec_ph;
    logic [31:0]        size_acc;
    logic [3:0]         digit_cnt;
    logic [31:0]        left_bytes;
    logic [COUNT_W-1:0] payload_total;

    result_t            pending_results [$];
    logic [BYTE_W-1:0]  body_q [$];
    drill_row_t         drill [DRILL_ROWS];

    int fail_count;
    int busy_items;
    bit src_idle_on;
    bit snk_idle_on;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, 4'(c - "0")};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
        begin
            return "0" + BYTE_W'(v);
        end
        return (upper ? "A" : "a") + BYTE_W'(v) - 8'd10;
    endfunction

    task automatic decoder_reset();
        dec_ph        = DEC_SIZE;
        size_acc      = '0;
        digit_cnt     = '0;
        left_bytes    = '0;
        payload_total = '0;
    endtask

    // A size line has ended: zero size ends the body, anything else opens data.
    task automatic close_size_line();
        if (size_acc == 0)
        begin
            dec_ph = DEC_DONE;
        end
        else
        begin
            left_bytes = size_acc;
            dec_ph     = DEC_DATA;
        end
        size_acc  = '0;
        digit_cnt = '0;
    endtask

    task automatic size_char(input logic [BYTE_W-1:0] c);
        logic [4:0] nib;
        nib = hex_nibble(c);
        if (nib[4])
        begin
            if (int'(digit_cnt) >= SIZE_DIGITS)
            begin
                dec_ph = DEC_ERROR;
            end
            else
            begin
                digit_cnt = digit_cnt + 4'd1;
                if (size_acc > 32'h0FFF_FFFF)
                begin
                    size_acc = '1;
                end
                else
                begin
                    size_acc = {size_acc[27:0], nib[3:0]};
                end
            end
        end
        else if (c == CH_LF)
        begin
            close_size_line();
        end
        else
        begin
            dec_ph = DEC_EXT;
        end
    endtask

    // Advance the predictor by one accepted byte and queue the results it causes.
    task automatic decode_byte(input logic [BYTE_W-1:0] c, input logic is_last,
                               input bit checked, input logic [STATUS_W-1:0] t_status,
                               input logic [COUNT_W-1:0] t_count);
        result_t r;
        case (dec_ph)
            DEC_SIZE:
            begin
                size_char(c);
            end
            DEC_EXT:
            begin
                if (c == CH_LF)
                begin
                    close_size_line();
                end
            end
            DEC_DATA:
            begin
                r.item_kind     = KIND_PAYLOAD;
                r.payload_byte  = c;
                r.end_status    = '0;
                r.payload_count = '0;
                pending_results.push_back(r);
                if (payload_total != '1)
                begin
                    payload_total = payload_total + 1;
                end
                left_bytes = left_bytes - 1;
                if (left_bytes == 0)
                begin
                    dec_ph = DEC_AFTER_DATA;
                end
            end
            DEC_AFTER_DATA:
            begin
                if (c == CH_CR)
                begin
                    dec_ph = DEC_AFTER_CR;
                end
                else
                begin
                    dec_ph = DEC_SIZE;
                    if (c != CH_LF)
                    begin
                        size_char(c);
                    end
                end
            end
            DEC_AFTER_CR:
            begin
                dec_ph = DEC_SIZE;
                if (c != CH_LF)
                begin
                    size_char(c);
                end
            end
            default:
            begin
            end
        endcase

        if (is_last)
        begin
            r.item_kind    = KIND_SUMMARY;
            r.payload_byte = '0;
            if (checked)
            begin
                r.end_status    = t_status;
                r.payload_count = t_count;
            end
            else
            begin
                if (dec_ph == DEC_DONE)
                begin
                    r.end_status = ST_TERMINATED;
                end
                else if (dec_ph == DEC_ERROR)
                begin
                    r.end_status = ST_SIZE_TOO_LONG;
                end
                else
                begin
                    r.end_status = ST_TRUNCATED;
                end
                r.payload_count = payload_total;
            end
            pending_results.push_back(r);
            decoder_reset();
        end
    endtask

    // Drive one byte transaction; called at a falling edge and returns at one.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_last,
                             input bit checked, input logic [STATUS_W-1:0] t_status,
                             input logic [COUNT_W-1:0] t_count);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        rx_if.valid      <= 1'b1;
        rx_if.input_byte <= data;
        rx_if.last_byte  <= is_last;
        @(posedge clk);
        while (!rx_if.ready)
        begin
            @(posedge clk);
        end
        // Bytes swallowed after the end of a body do not count as work.
        if (is_last || (dec_ph != DEC_DONE && dec_ph != DEC_ERROR))
        begin
            busy_items++;
        end
        decode_byte(data, is_last, checked, t_status, t_count);
        @(negedge clk);
    endtask

    // Hold the sender off until every queued result has been seen.
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic put_size(input logic [31:0] sz, input int lead, input bit upper);
        int nd;
        nd = 1;
        while (nd < 8 && (sz >> (4 * nd)) != 0)
        begin
            nd++;
        end
        repeat (lead) body_q.push_back("0");
        for (int i = nd - 1; i >= 0; i--)
        begin
            body_q.push_back(hex_char(sz[4*i +: 4], upper));
        end
    endtask

    task automatic put_eol();
        if ($urandom_range(0, 3) != 0)
        begin
            body_q.push_back(CH_CR);
        end
        body_q.push_back(CH_LF);
    endtask

    // Chunk extension: printable bytes, which may include hex digits.
    task automatic put_ext();
        body_q.push_back(";");
        repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    // Build one chunked body: mostly well formed, some cut, garbled or oversized.
    task automatic build_body();
        int unsigned sz;
        int          keep;
        body_q.delete();

        repeat ($urandom_range(0, 3))
        begin
            sz = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 8);
            put_size(sz, ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : 0,
                     1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
            begin
                put_ext();
            end
            put_eol();
            repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0: body_q.push_back(CH_LF);
                1: body_q.push_back(CH_CR);
                2: ;
                default:
                begin
                    body_q.push_back(CH_CR);
                    body_q.push_back(CH_LF);
                end
            endcase
        end

        // Terminating chunk, sometimes just an empty size line.
        if ($urandom_range(0, 7) == 0)
        begin
            body_q.push_back(CH_LF);
        end
        else
        begin
            put_size(0, $urandom_range(0, 2), 1'b0);
            if ($urandom_range(0, 5) == 0)
            begin
                put_ext();
            end
            put_eol();
        end

        // Trailer bytes after the end of the body.
        case ($urandom_range(0, 9))
            4, 5, 6:
            begin
                body_q.push_back(CH_CR);
                body_q.push_back(CH_LF);
            end
            7, 8, 9:
            begin
                repeat ($urandom_range(1, 5)) body_q.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase

        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    if (body_q.size() > 1)
                    begin
                        keep = $urandom_range(1, body_q.size() - 1);
                        while (body_q.size() > keep)
                        begin
                            void'(body_q.pop_back());
                        end
                    end
                end
                1:
                begin
                    body_q.delete();
                    repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    body_q.delete();
                    repeat ($urandom_range(SIZE_DIGITS, SIZE_DIGITS + 3))
                    begin
                        body_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                                  1'($urandom_range(0, 1))));
                    end
                    put_eol();
                    repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
                end
            endcase
        end
    endtask

    // Receiver: ready drops for random stretches while sink idling is on.
    initial
    begin
        int hold;
        hold          = 0;
        tx_if.ready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                tx_if.ready <= 1'b0;
                hold--;
            end
            else if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                tx_if.ready <= 1'b0;
                hold = $urandom_range(0, 6);
            end
            else
            begin
                tx_if.ready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected result: kind=%0d byte=%02h status=%0d count=%0d",
                             tx_if.item_kind, tx_if.payload_byte, tx_if.end_status,
                             tx_if.payload_count);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (tx_if.item_kind !== want.item_kind ||
                    tx_if.payload_byte !== want.payload_byte ||
                    tx_if.end_status !== want.end_status ||
                    tx_if.payload_count !== want.payload_count)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("result mismatch at %0t: expected kind=%0d byte=%02h",
                                 $realtime, want.item_kind, want.payload_byte);
                        $display("  status=%0d count=%0d, got kind=%0d byte=%02h",
                                 want.end_status, want.payload_count,
                                 tx_if.item_kind, tx_if.payload_byte);
                        $display("  status=%0d count=%0d",
                                 tx_if.end_status, tx_if.payload_count);
                    end
                end
            end
        end
    end

    // Hard limit on the run.
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus.
    initial
    begin
        bit mid_drained;
        bit tail;
        int n;

        rst_n            = 1'b0;
        rx_if.valid      = 1'b0;
        rx_if.input_byte = '0;
        rx_if.last_byte  = 1'b0;
        src_idle_on      = 1'b1;
        snk_idle_on      = 1'b1;
        fail_count       = 0;
        busy_items       = 0;
        mid_drained      = 1'b0;
        decoder_reset();

        // Directed bodies: empty size line, a ninth size digit, an extension with
        // a hex digit in it and both data extremes cut short, CR without LF after
        // data, a partial final chunk, and a zero size cut before its LF.
        drill = '{
            '{CH_LF,  1'b1, 1'b1, ST_TERMINATED,    32'd0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{"F",    1'b1, 1'b1, ST_SIZE_TOO_LONG, 32'd0},
            '{"2",    1'b0, 1'b0, '0, '0},
            '{";",    1'b0, 1'b0, '0, '0},
            '{"9",    1'b0, 1'b0, '0, '0},
            '{CH_LF,  1'b0, 1'b0, '0, '0},
            '{8'h00,  1'b0, 1'b0, '0, '0},
            '{8'hFF,  1'b1, 1'b1, ST_TRUNCATED,     32'd2},
            '{"1",    1'b0, 1'b0, '0, '0},
            '{CH_LF,  1'b0, 1'b0, '0, '0},
            '{"A",    1'b0, 1'b0, '0, '0},
            '{CH_CR,  1'b0, 1'b0, '0, '0},
            '{"0",    1'b0, 1'b0, '0, '0},
            '{CH_LF,  1'b1, 1'b1, ST_TERMINATED,    32'd1},
            '{"a",    1'b0, 1'b0, '0, '0},
            '{CH_LF,  1'b0, 1'b0, '0, '0},
            '{"x",    1'b1, 1'b1, ST_TRUNCATED,     32'd1},
            '{"0",    1'b1, 1'b1, ST_TRUNCATED,     32'd0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DRILL_ROWS; i++)
        begin
            send_byte(drill[i].data, drill[i].is_last, drill[i].checked,
                      drill[i].status, drill[i].count);
        end
        drain_results();

        // Random bodies, with quiet stretches and no idling at all near the end.
        busy_items = 0;
        while (busy_items < BUSY_TARGET)
        begin
            tail        = (busy_items >= CALM_FROM);
            src_idle_on = !tail && ($urandom_range(0, 3) != 0);
            snk_idle_on = !tail && ($urandom_range(0, 3) != 0);
            build_body();
            n = body_q.size();
            for (int i = 0; i < n; i++)
            begin
                send_byte(body_q[i], (i == n - 1), 1'b0, '0, '0);
            end
            if (!mid_drained && busy_items >= BUSY_TARGET / 2)
            begin
                drain_results();
                mid_drained = 1'b1;
            end
        end

        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
